### rtl/pit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants and types for the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Clock edges from the accepting edge to the edge that takes the result
    localparam int LATENCY = 5;

    // Result flags carried through the last stage
    typedef struct packed {
        logic in_tri;
        logic degenerate;
    } t_flags;

endpackage : pit_pkg
`default_nettype wire

### rtl/pit_cross.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_cross
// Two-stage 2-D cross product a.x*b.y - a.y*b.x: products registered,
// then the difference registered.
// ----------------------------------------------------------------------------
module pit_cross #(
    parameter int DW = 17
) (
    input  wire logic                  i_clk,
    input  wire logic signed [DW-1:0]  i_ax,
    input  wire logic signed [DW-1:0]  i_ay,
    input  wire logic signed [DW-1:0]  i_bx,
    input  wire logic signed [DW-1:0]  i_by,
    output logic signed [2*DW:0]       o_cross
);

    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    logic signed [PW-1:0] r_p0, r_p1;
    logic signed [CW-1:0] r_cross;

    // Stage A: the two partial products
    always_ff @(posedge i_clk) begin
        r_p0 <= i_ax * i_by;
        r_p1 <= i_ay * i_bx;
    end

    // Stage B: exact difference, one guard bit
    always_ff @(posedge i_clk) begin
        r_cross <= $signed({r_p0[PW-1], r_p0}) - $signed({r_p1[PW-1], r_p1});
    end

    assign o_cross = r_cross;

endmodule : pit_cross
`default_nettype wire

### rtl/point_in_triangle_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_triangle_test
// Exact barycentric point-in-triangle test on signed fixed-point coordinates.
// ----------------------------------------------------------------------------
// One test per clock: start may be held high every cycle and busy never
// rises. Each accepted beat produces one result, shown for one cycle with
// o_done high. The beat passes a five-stage pipeline: edge differences,
// products, cross products, sign normalization, final compare. The
// receiver cannot stall the pipeline; results must be taken as they
// appear. Points on an edge or a vertex count as inside; collinear
// vertices set o_degenerate with o_inside_res low.
module point_in_triangle_test
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [COORD_WIDTH-1:0]  i_point_x,
    input  wire logic [COORD_WIDTH-1:0]  i_point_y,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_a_x,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_a_y,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_b_x,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_b_y,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_c_x,
    input  wire logic [COORD_WIDTH-1:0]  i_vert_c_y,
    output logic                         o_done,
    output logic                         o_inside_res,
    output logic                         o_degenerate
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // edge vector component
    localparam int CW = 2 * DW + 1;     // cross product
    localparam int SW = CW + 2;         // normalized values, sums, compare

    // Valid bits that travel with the data
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 1: edge vectors v0 = C-A, v1 = B-A, v2 = P-A
    logic signed [DW-1:0] r_e0x, r_e0y, r_e1x, r_e1y, r_e2x, r_e2y;

    always_ff @(posedge i_clk) begin
        r_e0x <= $signed({i_vert_c_x[W-1], i_vert_c_x}) - $signed({i_vert_a_x[W-1], i_vert_a_x});
        r_e0y <= $signed({i_vert_c_y[W-1], i_vert_c_y}) - $signed({i_vert_a_y[W-1], i_vert_a_y});
        r_e1x <= $signed({i_vert_b_x[W-1], i_vert_b_x}) - $signed({i_vert_a_x[W-1], i_vert_a_x});
        r_e1y <= $signed({i_vert_b_y[W-1], i_vert_b_y}) - $signed({i_vert_a_y[W-1], i_vert_a_y});
        r_e2x <= $signed({i_point_x[W-1], i_point_x})   - $signed({i_vert_a_x[W-1], i_vert_a_x});
        r_e2y <= $signed({i_point_y[W-1], i_point_y})   - $signed({i_vert_a_y[W-1], i_vert_a_y});
    end

    // Stages 2-3: denominator and the two numerators
    logic signed [CW-1:0] den, nu, nv;

    pit_cross #(.DW(DW)) u_den (
        .i_clk(i_clk), .i_ax(r_e0x), .i_ay(r_e0y), .i_bx(r_e1x), .i_by(r_e1y),
        .o_cross(den)
    );

    pit_cross #(.DW(DW)) u_nu (
        .i_clk(i_clk), .i_ax(r_e2x), .i_ay(r_e2y), .i_bx(r_e1x), .i_by(r_e1y),
        .o_cross(nu)
    );

    pit_cross #(.DW(DW)) u_nv (
        .i_clk(i_clk), .i_ax(r_e0x), .i_ay(r_e0y), .i_bx(r_e2x), .i_by(r_e2y),
        .o_cross(nv)
    );

    // Stage 4: make the denominator non-negative, flag a zero denominator
    logic signed [SW-1:0] den_x, nu_x, nv_x;
    logic signed [SW-1:0] n_den, n_nu, n_nv;
    logic signed [SW-1:0] r_den, r_nu, r_nv;
    logic                 n_zero, r_zero;

    always_comb begin
        den_x  = SW'(den);
        nu_x   = SW'(nu);
        nv_x   = SW'(nv);
        n_zero = (den == '0);
        if (den[CW-1]) begin
            n_den = -den_x;
            n_nu  = -nu_x;
            n_nv  = -nv_x;
        end else begin
            n_den = den_x;
            n_nu  = nu_x;
            n_nv  = nv_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den  <= n_den;
        r_nu   <= n_nu;
        r_nv   <= n_nv;
        r_zero <= n_zero;
    end

    // Stage 5: u >= 0, v >= 0, u + v <= D
    logic signed [SW-1:0] slack;
    t_flags               n_flags, r_flags;

    always_comb begin
        slack   = r_den - (r_nu + r_nv);
        n_flags = '0;
        if (r_v4) begin
            n_flags.degenerate = r_zero;
            n_flags.in_tri     = ~r_zero & ~r_nu[SW-1] & ~r_nv[SW-1] & ~slack[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_done       = r_v5;
    assign o_inside_res = r_flags.in_tri;
    assign o_degenerate = r_flags.degenerate;

endmodule : point_in_triangle_test
`default_nettype wire

### rtl/pit_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks on the point-in-triangle test, bound to the top level.
// ----------------------------------------------------------------------------
module pit_checker
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [COORD_WIDTH-1:0]  i_vert_a_x,
    input wire logic [COORD_WIDTH-1:0]  i_vert_a_y,
    input wire logic [COORD_WIDTH-1:0]  i_vert_b_x,
    input wire logic [COORD_WIDTH-1:0]  i_vert_b_y,
    input wire logic                    o_done,
    input wire logic                    o_inside_res,
    input wire logic                    o_degenerate
);

    // Every result beat goes back to an earlier accepted beat
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching start");

    // A degenerate triangle never reports inside
    a_deg_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_degenerate |-> !o_inside_res)
        else $error("inside set on a degenerate triangle");

    // Result flags stay low between beats
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (!o_inside_res && !o_degenerate))
        else $error("result flags set without a beat");

    // Coincident vertices A and B must come back degenerate
    a_coincident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_vert_a_x == i_vert_b_x && i_vert_a_y == i_vert_b_y, LATENCY))
        |-> o_degenerate)
        else $error("coincident vertices not flagged degenerate");

endmodule : pit_checker

bind point_in_triangle_test pit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pit_checker (.*);
`default_nettype wire
